@@ src/ace_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ace_pkg;
  localparam int CODE_BITS_DEF = 16;
  localparam int FREQ_BITS_DEF = 14;
  localparam int MAX_RESULTS   = 16;
  localparam int PEND_W        = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;
endpackage
`default_nettype wire

@@ src/ace_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ace_in_if #(
  parameter int FREQ_BITS = 14
);
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [FREQ_BITS-1:0] cum_low;
  logic [FREQ_BITS-1:0] cum_high;
  logic [FREQ_BITS-1:0] total;

  modport source (output valid, command, cum_low, cum_high, total, input ready);
  modport sink (input valid, command, cum_low, cum_high, total, output ready);
endinterface
`default_nettype wire

@@ src/ace_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface ace_out_if #(
  parameter int PEND_W = 32
);
  logic              valid;
  logic              ready;
  logic              out_bit;
  logic [PEND_W-1:0] follow_count;
  logic              last;

  modport source (output valid, out_bit, follow_count, last, input ready);
  modport sink (input valid, out_bit, follow_count, last, output ready);
endinterface
`default_nettype wire

@@ src/ace_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ace_front import ace_pkg::*; #(
  parameter int FREQ_BITS = FREQ_BITS_DEF,
  localparam int EW = 1 + 3 * FREQ_BITS
) (
  ace_in_if.sink        in_ch,
  input  wire logic     q_ready,
  output logic          q_push,
  output logic [EW-1:0] q_data
);
  logic range_ok;

  // bad symbol ranges are dropped here and never reach the coder
  assign range_ok = (in_ch.total != '0) && (in_ch.cum_low < in_ch.cum_high) &&
                    (in_ch.cum_high <= in_ch.total);
  assign in_ch.ready = q_ready;
  assign q_push = in_ch.valid && q_ready &&
                  ((in_ch.command == CMD_FINISH) || range_ok);
  assign q_data = {in_ch.command, in_ch.cum_low, in_ch.cum_high, in_ch.total};
endmodule
`default_nettype wire

@@ src/ace_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ace_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  push_ready,
  input  wire logic             pop,
  output logic                  pop_valid,
  output logic [WIDTH-1:0]      pop_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_data;
    end
  end
endmodule
`default_nettype wire

@@ src/ace_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ace_back import ace_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF,
  localparam int EW = 1 + 3 * FREQ_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire logic [EW-1:0] q_data,
  output logic               q_pop,
  ace_out_if.source          out_ch
);
  localparam int RW  = CODE_BITS + 1;
  localparam int PW  = RW + FREQ_BITS;
  localparam int DCW = $clog2(PW);
  localparam int NW  = $clog2(MAX_RESULTS + 1);
  localparam logic [CODE_BITS-1:0] TOP = '1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FLUSH, ST_MUL, ST_DIV, ST_NARROW, ST_RENORM, ST_UNDER
  } state_t;

  state_t               st_r, st_nxt;
  logic [CODE_BITS-1:0] low_r, low_nxt, high_r, high_nxt;
  logic [PEND_W-1:0]    pend_r, pend_nxt, pend_inc;
  logic [FREQ_BITS-1:0] cl_r, cl_nxt, ch_r, ch_nxt, tot_r, tot_nxt;
  logic [PW-1:0]        ph_r, ph_nxt, pl_r, pl_nxt;
  logic [FREQ_BITS-1:0] rh_r, rh_nxt, rl_r, rl_nxt;
  logic [DCW-1:0]       dcnt_r, dcnt_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 ov_r, ov_nxt, ob_r, ob_nxt, ol_r, ol_nxt;
  logic [PEND_W-1:0]    of_r, of_nxt;

  logic                 out_free, out_load;
  logic [RW-1:0]        range;
  logic [FREQ_BITS:0]   trial_h, trial_l;
  logic                 ge_h, ge_l;
  logic [CODE_BITS-1:0] sh_low, sh_high;
  logic                 agree, agree_next;

  assign out_free = !ov_r || out_ch.ready;
  assign pend_inc = (pend_r == '1) ? pend_r : pend_r + 1'b1;
  assign range    = {1'b0, high_r} - {1'b0, low_r} + RW'(1);

  // one quotient bit per cycle for both bounds
  assign trial_h = {rh_r, ph_r[PW-1]};
  assign trial_l = {rl_r, pl_r[PW-1]};
  assign ge_h    = trial_h >= {1'b0, tot_r};
  assign ge_l    = trial_l >= {1'b0, tot_r};

  assign agree      = !(low_r[CODE_BITS-1] ^ high_r[CODE_BITS-1]);
  assign sh_low     = {low_r[CODE_BITS-2:0], 1'b0};
  assign sh_high    = {high_r[CODE_BITS-2:0], 1'b1};
  assign agree_next = !(sh_low[CODE_BITS-1] ^ sh_high[CODE_BITS-1]);

  always_comb begin
    st_nxt   = st_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    pend_nxt = pend_r;
    cl_nxt   = cl_r;
    ch_nxt   = ch_r;
    tot_nxt  = tot_r;
    ph_nxt   = ph_r;
    pl_nxt   = pl_r;
    rh_nxt   = rh_r;
    rl_nxt   = rl_r;
    dcnt_nxt = dcnt_r;
    cnt_nxt  = cnt_r;
    ob_nxt   = ob_r;
    of_nxt   = of_r;
    ol_nxt   = ol_r;
    out_load = 1'b0;
    q_pop    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cl_nxt  = q_data[3*FREQ_BITS-1:2*FREQ_BITS];
          ch_nxt  = q_data[2*FREQ_BITS-1:FREQ_BITS];
          tot_nxt = q_data[FREQ_BITS-1:0];
          st_nxt  = (q_data[EW-1] == CMD_FINISH) ? ST_FLUSH : ST_MUL;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          ob_nxt   = (low_r[CODE_BITS-1:CODE_BITS-2] != 2'b00);
          of_nxt   = pend_inc;
          ol_nxt   = 1'b1;
          low_nxt  = '0;
          high_nxt = TOP;
          pend_nxt = '0;
          st_nxt   = ST_IDLE;
        end
      end
      ST_MUL: begin
        ph_nxt   = PW'(range) * PW'(ch_r);
        pl_nxt   = PW'(range) * PW'(cl_r);
        rh_nxt   = '0;
        rl_nxt   = '0;
        dcnt_nxt = '0;
        st_nxt   = ST_DIV;
      end
      ST_DIV: begin
        rh_nxt   = ge_h ? FREQ_BITS'(trial_h - {1'b0, tot_r}) : trial_h[FREQ_BITS-1:0];
        rl_nxt   = ge_l ? FREQ_BITS'(trial_l - {1'b0, tot_r}) : trial_l[FREQ_BITS-1:0];
        ph_nxt   = {ph_r[PW-2:0], ge_h};
        pl_nxt   = {pl_r[PW-2:0], ge_l};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(PW - 1)) begin
          st_nxt = ST_NARROW;
        end
      end
      ST_NARROW: begin
        high_nxt = low_r + ph_r[CODE_BITS-1:0] - 1'b1;
        low_nxt  = low_r + pl_r[CODE_BITS-1:0];
        cnt_nxt  = '0;
        st_nxt   = ST_RENORM;
      end
      ST_RENORM: begin
        if (!agree) begin
          st_nxt = ST_UNDER;
        end else if (cnt_r == NW'(MAX_RESULTS)) begin
          // cap reached: leave the interval as it stands
          st_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          ob_nxt   = low_r[CODE_BITS-1];
          of_nxt   = pend_r;
          ol_nxt   = !(agree_next && (cnt_r != NW'(MAX_RESULTS - 1)));
          pend_nxt = '0;
          low_nxt  = sh_low;
          high_nxt = sh_high;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      ST_UNDER: begin
        if (low_r[CODE_BITS-2] && !high_r[CODE_BITS-2]) begin
          pend_nxt = pend_inc;
          low_nxt  = {1'b0, low_r[CODE_BITS-3:0], 1'b0};
          high_nxt = {1'b1, high_r[CODE_BITS-3:0], 1'b1};
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
    ov_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      low_r  <= '0;
      high_r <= TOP;
      pend_r <= '0;
      ov_r   <= 1'b0;
      dcnt_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
      dcnt_r <= dcnt_nxt;
      cnt_r  <= cnt_nxt;
    end
    cl_r  <= cl_nxt;
    ch_r  <= ch_nxt;
    tot_r <= tot_nxt;
    ph_r  <= ph_nxt;
    pl_r  <= pl_nxt;
    rh_r  <= rh_nxt;
    rl_r  <= rl_nxt;
    ob_r  <= ob_nxt;
    of_r  <= of_nxt;
    ol_r  <= ol_nxt;
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.out_bit      = ob_r;
  assign out_ch.follow_count = of_r;
  assign out_ch.last         = ol_r;

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NW'(MAX_RESULTS))
    else $error("result count past cap");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && ov_r) |-> out_ch.ready)
    else $error("output word overwritten");

  a_flush_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FLUSH && out_free) |=> (low_r == '0 && high_r == TOP && pend_r == '0))
    else $error("state not restored after finish");

  a_pend_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RENORM && out_load) |=> (pend_r == '0))
    else $error("pending count kept after emit");
endmodule
`default_nettype wire

@@ src/arithmetic_encoder_core.sv @@
// encode word: dequeue, multiply, (CODE_BITS+1+FREQ_BITS) divide steps and narrow,
// then renormalise: emit one bit per agreeing top bit, then widen once per underflow step
// (at most MAX_RESULTS bits per word; when that cap is hit the underflow steps are skipped)
// finish word: a final bit marked last; bad ranges are dropped at the front in the accept cycle
// throughput set by the one-bit-per-cycle restoring dividers; a 2-entry queue decouples input
// synchronous active-low reset: interval low 0, high all ones, pending count 0
`timescale 1ns / 1ps
`default_nettype none
module arithmetic_encoder_core import ace_pkg::*; #(
  parameter int CODE_BITS = CODE_BITS_DEF,
  parameter int FREQ_BITS = FREQ_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ace_in_if.sink    in_ch,
  ace_out_if.source out_ch
);
  localparam int EW = 1 + 3 * FREQ_BITS;

  logic          q_push, q_ready, q_pop, q_valid;
  logic [EW-1:0] q_wdata, q_rdata;

  ace_front #(.FREQ_BITS(FREQ_BITS)) u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  ace_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_rdata)
  );

  ace_back #(.CODE_BITS(CODE_BITS), .FREQ_BITS(FREQ_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import ace_pkg::*;

  localparam int CB = CODE_BITS_DEF;
  localparam int FB = FREQ_BITS_DEF;
  localparam int NUM_RANDOM = 440;
  localparam int CALM_TAIL = 60;

  typedef struct {
    bit        code_bit;
    bit [31:0] follow;
    bit        last;
  } code_word_t;

  class coder_scoreboard;
    bit [CB-1:0]  lo;
    bit [CB-1:0]  hi;
    bit [31:0]    pending;
    code_word_t   bits_due[$];
    int           errors;
    int           words_in;
    int           words_out;
    int           finishes;
    int           dropped;

    function new();
      lo = '0;
      hi = '1;
      pending = 0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      finishes = 0;
      dropped = 0;
    endfunction

    function void bump();
      if (pending != 32'hFFFF_FFFF) pending++;
    endfunction

    function void emit(bit b);
      code_word_t w;
      w.code_bit = b;
      w.follow = pending;
      w.last = 1'b0;
      bits_due.push_back(w);
      pending = 0;
    endfunction

    function void note_word(bit cmd, bit [FB-1:0] cl, bit [FB-1:0] ch, bit [FB-1:0] tot);
      bit [CB:0]      span;
      bit [CB+FB:0]   prod_h;
      bit [CB+FB:0]   prod_l;
      bit [CB+FB:0]   q_h;
      bit [CB+FB:0]   q_l;
      int             n;
      bit             capped;
      words_in++;
      if (cmd == CMD_FINISH) begin
        finishes++;
        bump();
        emit(lo < (1 << (CB - 2)) ? 1'b0 : 1'b1);
        bits_due[bits_due.size()-1].last = 1'b1;
        lo = '0;
        hi = '1;
        pending = 0;
        return;
      end
      if (tot == 0 || cl >= ch || ch > tot) begin
        dropped++;
        return;
      end
      span = {1'b0, hi} - {1'b0, lo} + 1'b1;
      prod_h = span * ch;
      prod_l = span * cl;
      q_h = prod_h / tot;
      q_l = prod_l / tot;
      hi = lo + q_h[CB-1:0] - 1'b1;
      lo = lo + q_l[CB-1:0];
      n = 0;
      capped = 0;
      while (lo[CB-1] == hi[CB-1]) begin
        if (n >= MAX_RESULTS) begin
          capped = 1;
          break;
        end
        emit(lo[CB-1]);
        n++;
        lo = {lo[CB-2:0], 1'b0};
        hi = {hi[CB-2:0], 1'b1};
      end
      // underflow: low 01.., high 10.., widen about the middle
      if (!capped) begin
        while (lo[CB-2] && !hi[CB-2]) begin
          bump();
          lo = {1'b0, lo[CB-3:0], 1'b0};
          hi = {1'b1, hi[CB-3:0], 1'b1};
        end
      end
      if (n > 0) bits_due[bits_due.size()-1].last = 1'b1;
    endfunction

    function void check_word(bit b, bit [31:0] fc, bit lst);
      code_word_t w;
      words_out++;
      if (bits_due.size() == 0) begin
        $display("%0t: unexpected word: bit %0d follow %0d last %0d", $time, b, fc, lst);
        errors++;
        return;
      end
      w = bits_due.pop_front();
      if (w.code_bit != b) begin
        $display("%0t: out_bit expected %0d actual %0d", $time, w.code_bit, b);
        errors++;
      end
      if (w.follow != fc) begin
        $display("%0t: follow_count expected %0d actual %0d", $time, w.follow, fc);
        errors++;
      end
      if (w.last != lst) begin
        $display("%0t: last expected %0d actual %0d", $time, w.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ace_in_if #(.FREQ_BITS(FB)) in_ch ();
  ace_out_if #(.PEND_W(PEND_W)) out_ch ();

  arithmetic_encoder_core #(.CODE_BITS(CB), .FREQ_BITS(FB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  coder_scoreboard sb;
  bit calm;
  bit run_started;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.command, in_ch.cum_low, in_ch.cum_high, in_ch.total);
      if (out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.out_bit, out_ch.follow_count, out_ch.last);
    end
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    int cyc;
    int stall_left;
    cyc = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    wait (run_started);
    forever begin
      @(negedge clk);
      cyc++;
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (cyc >= 600 && cyc < 1400) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(bit cmd, bit [FB-1:0] cl, bit [FB-1:0] ch, bit [FB-1:0] tot);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.cum_low <= cl;
    in_ch.cum_high <= ch;
    in_ch.total <= tot;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
  endtask

  task automatic maybe_gap();
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 7);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic send_symbol(bit [FB-1:0] cl, bit [FB-1:0] ch, bit [FB-1:0] tot);
    maybe_gap();
    send_word(CMD_ENCODE, cl, ch, tot);
  endtask

  task automatic send_random();
    int pick;
    int t;
    int l;
    int h;
    pick = $urandom_range(0, 99);
    maybe_gap();
    if (pick < 5) begin
      send_word(CMD_FINISH, FB'($urandom), FB'($urandom), FB'($urandom));
    end else if (pick < 10) begin
      // raw fields, mostly bad ranges
      send_word(CMD_ENCODE, FB'($urandom), FB'($urandom), FB'($urandom));
    end else if (pick < 25) begin
      // symbols around the middle drive the underflow path
      t = $urandom_range(4, 16383);
      l = t / 4 + $urandom_range(0, t / 8);
      h = (3 * t) / 4 - $urandom_range(0, t / 8);
      if (h <= l) h = l + 1;
      send_word(CMD_ENCODE, FB'(l), FB'(h), FB'(t));
    end else begin
      t = (pick < 45) ? $urandom_range(1, 8) : $urandom_range(1, 16383);
      l = $urandom_range(0, t - 1);
      h = $urandom_range(l + 1, t);
      send_word(CMD_ENCODE, FB'(l), FB'(h), FB'(t));
    end
  endtask

  initial begin
    int waited;
    sb = new();
    calm = 0;
    run_started = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ENCODE;
    in_ch.cum_low = '0;
    in_ch.cum_high = '0;
    in_ch.total = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_started = 1;

    send_word(CMD_FINISH, '0, '0, '0);
    send_symbol(0, 16383, 16383);
    send_symbol(0, 1, 16383);
    send_symbol(16382, 16383, 16383);
    send_symbol(0, 1, 1);
    send_symbol(5, 9, 0);
    send_symbol(7, 7, 100);
    send_symbol(9, 3, 100);
    send_symbol(1, 16383, 16382);
    send_symbol(1, 3, 4);
    send_symbol(1, 3, 4);
    send_symbol(1, 3, 4);
    send_symbol(1, 2, 4);
    send_word(CMD_FINISH, '1, '1, '1);
    send_symbol(2, 3, 3);
    send_word(CMD_FINISH, '0, '0, '0);
    repeat (6) send_symbol(1, 3, 4);
    send_symbol(8191, 8192, 16383);
    send_word(CMD_FINISH, '0, '0, '0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i >= NUM_RANDOM - CALM_TAIL) calm = 1;
      send_random();
    end
    send_word(CMD_FINISH, '0, '0, '0);
    @(negedge clk);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (sb.bits_due.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.bits_due.size() != 0) begin
      $display("%0t: code words expected %0d more actual 0", $time, sb.bits_due.size());
      sb.errors++;
    end

    $display("run covered %0d input words (%0d finish, %0d bad ranges), %0d code words out",
             sb.words_in, sb.finishes, sb.dropped, sb.words_out);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
